[sv/rmss_pkg.sv]
// ---------------------------------------------------------------------------
// rmss_pkg
// Shared types, codes and constants of the RMS mode segment screen.
// ---------------------------------------------------------------------------
`default_nettype none

package rmss_pkg;

   localparam int MAX_CHANNELS_DEF = 16;
   localparam int NUM_BINS_DEF     = 20;

   localparam int COUNT_W   = 16;
   localparam int BIN_MAX_W = 5;
   localparam int ALLOW_W   = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int BIN_LOW     = 50;
   localparam int BIN_STEP    = 100;
   localparam int HALF_BIN    = 50;
   // d / 100 as (d * 5243) >> 19, exact for d below 43690
   localparam int RECIP       = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = 29;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_ACCUM = 2'd1;
   localparam logic [1:0] KIND_EVAL  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  channel;
      logic [15:0] segment;
      logic [15:0] rms_value;
      logic        last_channel;
   } req_type;

   typedef struct packed {
      logic [15:0] segment_out;
      logic        segment_valid;
   } rsp_type;

   typedef struct packed {
      logic                 in_range;
      logic [BIN_MAX_W-1:0] bin;
   } bin_info_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

`default_nettype wire

[sv/rmss_ram.sv]
// ---------------------------------------------------------------------------
// rmss_ram
// Generic single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rmss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/rmss_binner.sv]
// ---------------------------------------------------------------------------
// rmss_binner
// Maps an RMS value to its histogram bin and flags values outside all bins.
// ---------------------------------------------------------------------------
`default_nettype none

module rmss_binner #(
   parameter int NUM_BINS = rmss_pkg::NUM_BINS_DEF
) (
   input  wire logic [15:0]            rms_value,
   output rmss_pkg::bin_info_type      bin_info
);

   localparam logic [15:0] SPAN = 16'(NUM_BINS * rmss_pkg::BIN_STEP);

   logic [15:0]                  offset;
   logic [rmss_pkg::PROD_W-1:0]  prod;
   logic [rmss_pkg::PROD_W-1:0]  quot;

   always_comb begin
      offset = rms_value - 16'(rmss_pkg::BIN_LOW);
      prod   = rmss_pkg::PROD_W'(offset) * rmss_pkg::PROD_W'(rmss_pkg::RECIP);
      quot   = prod >> rmss_pkg::RECIP_SHIFT;
      bin_info.in_range = (rms_value >= 16'(rmss_pkg::BIN_LOW)) && (offset < SPAN);
      bin_info.bin      = rmss_pkg::BIN_MAX_W'(quot);
   end

endmodule

`default_nettype wire

[sv/rms_mode_segment_screen.sv]
// ---------------------------------------------------------------------------
// rms_mode_segment_screen
// Per-channel RMS histograms with running mode, and segment screening.
// ---------------------------------------------------------------------------
// Accumulate, evaluate and unused items go through ST_IDLE and ST_EXEC: the
// accept cycle reads the bin count and channel mode memories, and ST_EXEC
// does the read-modify-write of an in-range accumulate or the mode check of
// an evaluate. A clear item starts a clearing pass through all entries of
// the bin memory, which also clears the mode memory; the same pass runs
// after reset. No request is accepted during the pass. An evaluate that
// closes a segment holds in ST_EXEC until the result register is free. The
// allowance register may be written at any time through csr_.
`default_nettype none

module rms_mode_segment_screen #(
   parameter int MAX_CHANNELS = rmss_pkg::MAX_CHANNELS_DEF,
   parameter int NUM_BINS     = rmss_pkg::NUM_BINS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire rmss_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output rmss_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rmss_pkg::ALLOW_W-1:0]  csr_data
);

   localparam int DEPTH  = MAX_CHANNELS * NUM_BINS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int CNT_W  = rmss_pkg::COUNT_W;
   localparam int MODE_W = CNT_W + BIN_W;

   rmss_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                seg_ok_ff, seg_ok_in;
   logic [rmss_pkg::ALLOW_W-1:0] allow_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rmss_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                is_acc_ff, is_eval_ff, ch_ok_ff, last_ff;
   logic [BIN_W-1:0]    bin_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [CH_W-1:0]     ch_ff;
   logic [15:0]         value_ff, segment_ff;
   logic                load;

   rmss_pkg::bin_info_type bin_info;
   logic [CH_W-1:0]     req_ch;
   logic                req_ch_ok;
   logic [BIN_W-1:0]    req_bin;
   logic [ADDR_W-1:0]   req_addr;

   logic [ADDR_W-1:0]   bin_addr;
   logic                bin_we;
   logic [CNT_W-1:0]    bin_wdata, bin_rdata;
   logic [CH_W-1:0]     mode_addr;
   logic                mode_we;
   logic [MODE_W-1:0]   mode_wdata, mode_rdata;

   logic [CNT_W-1:0]    cnt_new, mode_cnt;
   logic [BIN_W-1:0]    mode_b;
   logic                mode_upd;
   logic [15:0]         centre, diff, tol;
   logic                ok_next, rsp_free;

   rmss_binner #(.NUM_BINS(NUM_BINS)) u_binner (
      .rms_value (req_data.rms_value),
      .bin_info  (bin_info)
   );

   rmss_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_bin_ram (
      .clock   (clock),
      .we      (bin_we),
      .addr    (bin_addr),
      .wr_data (bin_wdata),
      .rd_data (bin_rdata)
   );

   rmss_ram #(.WIDTH(MODE_W), .DEPTH(MAX_CHANNELS), .AW(CH_W)) u_mode_ram (
      .clock   (clock),
      .we      (mode_we),
      .addr    (mode_addr),
      .wr_data (mode_wdata),
      .rd_data (mode_rdata)
   );

   always_comb begin
      req_ch    = CH_W'(req_data.channel);
      req_ch_ok = int'(req_data.channel) < MAX_CHANNELS;
      req_bin   = BIN_W'(bin_info.bin);
      req_addr  = ADDR_W'(int'(req_ch) * NUM_BINS + int'(req_bin));

      cnt_new  = (bin_rdata == rmss_pkg::COUNT_MAX) ? bin_rdata : bin_rdata + 1'b1;
      mode_cnt = mode_rdata[BIN_W +: CNT_W];
      mode_b   = mode_rdata[BIN_W-1:0];
      mode_upd = (cnt_new > mode_cnt) || ((cnt_new == mode_cnt) && (bin_ff < mode_b));

      centre  = 16'((int'(mode_b) + 1) * rmss_pkg::BIN_STEP);
      diff    = (value_ff >= centre) ? (value_ff - centre) : (centre - value_ff);
      tol     = 16'(int'(allow_ff) * rmss_pkg::BIN_STEP + rmss_pkg::HALF_BIN);
      ok_next = seg_ok_ff && !(ch_ok_ff && (diff > tol));
      rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      seg_ok_in    = seg_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      load         = 1'b0;
      bin_addr     = addr_ff;
      bin_we       = 1'b0;
      bin_wdata    = cnt_new;
      mode_addr    = ch_ff;
      mode_we      = 1'b0;
      mode_wdata   = {cnt_new, bin_ff};
      case (state_ff)
         rmss_pkg::ST_CLEAR: begin
            bin_addr   = clr_ff;
            bin_we     = 1'b1;
            bin_wdata  = '0;
            mode_addr  = CH_W'(clr_ff);
            mode_we    = int'(clr_ff) < MAX_CHANNELS;
            mode_wdata = '0;
            clr_in     = ADDR_W'(int'(clr_ff) + 1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = rmss_pkg::ST_IDLE;
            end
         end
         rmss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            bin_addr  = req_addr;
            mode_addr = req_ch;
            if (req_valid) begin
               if (req_data.kind == rmss_pkg::KIND_CLEAR) begin
                  state_in  = rmss_pkg::ST_CLEAR;
                  clr_in    = '0;
                  seg_ok_in = 1'b1;
               end else begin
                  state_in = rmss_pkg::ST_EXEC;
                  load     = 1'b1;
               end
            end
         end
         rmss_pkg::ST_EXEC: begin
            if (is_acc_ff) begin
               bin_we   = 1'b1;
               mode_we  = mode_upd;
               state_in = rmss_pkg::ST_IDLE;
            end else if (is_eval_ff && last_ff) begin
               if (rsp_free) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.segment_out   = segment_ff;
                  rsp_data_in.segment_valid = ok_next;
                  seg_ok_in                 = 1'b1;
                  state_in                  = rmss_pkg::ST_IDLE;
               end
            end else if (is_eval_ff) begin
               seg_ok_in = ok_next;
               state_in  = rmss_pkg::ST_IDLE;
            end else begin
               state_in = rmss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmss_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmss_pkg::ST_CLEAR;
         clr_ff       <= '0;
         seg_ok_ff    <= 1'b1;
         allow_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seg_ok_ff    <= seg_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            allow_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load) begin
         is_acc_ff  <= (req_data.kind == rmss_pkg::KIND_ACCUM) && req_ch_ok
                       && bin_info.in_range;
         is_eval_ff <= req_data.kind == rmss_pkg::KIND_EVAL;
         ch_ok_ff   <= req_ch_ok;
         last_ff    <= req_data.last_channel;
         bin_ff     <= req_bin;
         addr_ff    <= req_addr;
         ch_ff      <= req_ch;
         value_ff   <= req_data.rms_value;
         segment_ff <= req_data.segment;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.kind == rmss_pkg::KIND_CLEAR)
      |=> state_ff == rmss_pkg::ST_CLEAR)
      else $error("clear request did not start the clearing pass");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (bin_we || mode_we) |-> state_ff != rmss_pkg::ST_IDLE)
      else $error("memory written while idle");

   a_pass_writes_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == rmss_pkg::ST_CLEAR |-> (bin_we && bin_wdata == '0))
      else $error("clearing pass wrote a nonzero count");

   a_mode_follows_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmss_pkg::ST_EXEC && mode_we) |-> bin_we)
      else $error("mode updated without a count update");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rmss_pkg::ST_EXEC)
      else $error("result raised outside an evaluate");

endmodule

`default_nettype wire
